// ===== rtl/cora_pkg.sv =====
// shared types and constants of the clock offset and rtt average block
`default_nettype none

package cora_pkg;

  localparam int CORA_WINDOW = 10;
  localparam int CORA_TIME_W = 63;
  localparam int CORA_OFF_W  = 64;
  localparam int CORA_SER_W  = 64;
  localparam int CORA_RTT_W  = 40;
  localparam int CORA_SUM_W  = 47;
  localparam int CORA_HELD_W = 7;

  localparam logic signed [CORA_RTT_W-1:0] CORA_RTT_MAX = {1'b0, {(CORA_RTT_W-1){1'b1}}};
  localparam logic signed [CORA_RTT_W-1:0] CORA_RTT_MIN = {1'b1, {(CORA_RTT_W-1){1'b0}}};

  typedef struct packed {
    logic [CORA_TIME_W-1:0] send_time;
    logic [CORA_TIME_W-1:0] center_time;
    logic [CORA_TIME_W-1:0] now_time;
  } cora_in_t;

  typedef struct packed {
    logic                          accepted;
    logic signed [CORA_OFF_W-1:0]  time_offset;
    logic signed [CORA_RTT_W-1:0]  average_rtt;
    logic [CORA_TIME_W-1:0]        previous_center_time;
    logic [CORA_HELD_W-1:0]        samples_held;
  } cora_out_t;

  // results of the bit-serial front end
  typedef struct packed {
    logic                   done;
    logic                   older;
    logic [CORA_SER_W-1:0]  rtt_diff;
    logic [CORA_SER_W-1:0]  offset;
  } cora_ser_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SER,
    S_UPD,
    S_DIV,
    S_DONE
  } cora_state_t;

endpackage

`default_nettype wire

// ===== rtl/cora_serial.sv =====
// bit-serial subtractors: age check, rtt difference and clock offset
`default_nettype none

module cora_serial (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire cora_pkg::cora_in_t              item,
  input  wire logic [cora_pkg::CORA_TIME_W-1:0] latest,
  output cora_pkg::cora_ser_res_t              res
);
  import cora_pkg::*;

  localparam int CW = $clog2(CORA_SER_W);

  logic [CORA_SER_W-1:0] cen_r, now_r, snd_r, lat_r, rtt_r, off_r;
  logic                  b_rtt_r, b_off_r, b_cmp_r;
  logic [CW-1:0]         cnt_r;
  logic                  busy_r, done_r;

  logic d_rtt, d_off, n_rtt, n_off, n_cmp;

  // one-bit subtract a - b - borrow
  always_comb begin
    d_rtt = now_r[0] ^ snd_r[0] ^ b_rtt_r;
    n_rtt = (~now_r[0] & snd_r[0]) | (~(now_r[0] ^ snd_r[0]) & b_rtt_r);
    d_off = cen_r[0] ^ now_r[0] ^ b_off_r;
    n_off = (~cen_r[0] & now_r[0]) | (~(cen_r[0] ^ now_r[0]) & b_off_r);
    n_cmp = (~cen_r[0] & lat_r[0]) | (~(cen_r[0] ^ lat_r[0]) & b_cmp_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(CORA_SER_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cen_r   <= {1'b0, item.center_time};
      now_r   <= {1'b0, item.now_time};
      snd_r   <= {1'b0, item.send_time};
      lat_r   <= {1'b0, latest};
      b_rtt_r <= 1'b0;
      b_off_r <= 1'b0;
      b_cmp_r <= 1'b0;
    end else if (busy_r) begin
      cen_r   <= {1'b0, cen_r[CORA_SER_W-1:1]};
      now_r   <= {1'b0, now_r[CORA_SER_W-1:1]};
      snd_r   <= {1'b0, snd_r[CORA_SER_W-1:1]};
      lat_r   <= {1'b0, lat_r[CORA_SER_W-1:1]};
      rtt_r   <= {d_rtt, rtt_r[CORA_SER_W-1:1]};
      off_r   <= {d_off, off_r[CORA_SER_W-1:1]};
      b_rtt_r <= n_rtt;
      b_off_r <= n_off;
      b_cmp_r <= n_cmp;
    end
  end

  // final borrow of center - latest means the reply went backwards
  assign res.done     = done_r;
  assign res.older    = b_cmp_r;
  assign res.rtt_diff = rtt_r;
  assign res.offset   = off_r;

endmodule

`default_nettype wire

// ===== rtl/cora_div.sv =====
// serial restoring divider, signed sum over the fill count, truncating
`default_nettype none

module cora_div #(
  parameter int DW = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire logic signed [cora_pkg::CORA_SUM_W-1:0] dividend,
  input  wire logic [DW-1:0]                         divisor,
  output logic                                       done,
  output logic signed [cora_pkg::CORA_RTT_W-1:0]      quotient
);
  import cora_pkg::*;

  localparam int SW = CORA_SUM_W;
  localparam int CW = $clog2(SW);

  logic [SW-1:0] quo_r;
  logic [DW-1:0] rem_r, div_r;
  logic          neg_r, busy_r, done_r;
  logic [CW-1:0] cnt_r;

  logic [DW:0]   rem_sh, rem_sub;
  logic          ge;
  logic [SW-1:0] q_signed;

  always_comb begin
    rem_sh  = {rem_r, quo_r[SW-1]};
    ge      = rem_sh >= {1'b0, div_r};
    rem_sub = rem_sh - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(SW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SW-1];
      quo_r <= dividend[SW-1] ? (~dividend + 1'b1) : dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SW-2:0], ge};
      rem_r <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  // magnitude quotient, sign restored for truncation toward zero
  assign q_signed = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient = q_signed[CORA_RTT_W-1:0];
  assign done     = done_r;

endmodule

`default_nettype wire

// ===== rtl/clock_offset_and_rtt_average_top.sv =====
// top level: time-sync reply check, clock offset and windowed rtt average
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------
//   in      | input     | in_valid/in_stall  | cora_in_t  (send, center, now)
//   out     | output    | out_valid/out_stall| cora_out_t (accepted, offset,
//           |           |                    |   average, previous, held)
//
// one reply at a time; an accepted reply goes through the 64-step bit-serial
// subtractor pass and then the 47-step serial divider, a rejected one through
// the subtractor pass only.
// synchronous active-low reset clears control, counters and held times.
// the result sits in an output register, so the next input transfer is taken
// while a result is still stalled; the block only waits at the end of an item
// for that register to free up.
`default_nettype none

module clock_offset_and_rtt_average_top #(
  parameter int WINDOW = cora_pkg::CORA_WINDOW
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire cora_pkg::cora_in_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output cora_pkg::cora_out_t      out_item
);
  import cora_pkg::*;

  localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW = $clog2(WINDOW + 1);
  localparam int SW = CORA_SUM_W;
  localparam int RW = CORA_RTT_W;

  // fsm
  cora_state_t state_r, state_nxt;

  // held state
  logic [CORA_TIME_W-1:0]       latest_r, prior_r;
  logic signed [CORA_OFF_W-1:0] off_r;
  logic signed [SW-1:0]         sum_r;
  logic signed [RW-1:0]         avg_r;
  logic [PW-1:0]                pos_r;
  logic [FW-1:0]                fill_r;
  logic                         acc_r;

  // per-item working values
  logic signed [RW-1:0]         rtt_new_r;
  logic signed [RW-1:0]         rd_r;
  logic signed [SW-1:0]         sum_nxt;
  logic [FW-1:0]                fill_nxt;
  logic                         full;
  logic signed [RW-1:0]         rtt_sat;
  logic                         rtt_fits;

  // the center time of the item under work, held for the commit
  logic [CORA_TIME_W-1:0]       in_center_r;

  // control strobes
  logic ser_start, commit, ring_upd, div_start, out_load;

  // output register
  cora_out_t out_item_r;
  logic      out_valid_r;

  // ring memory, never cleared; entries are used only once the window is full
  logic signed [RW-1:0] ring_mem [WINDOW];

  cora_ser_res_t        ser;
  logic                 div_done;
  logic signed [RW-1:0] div_q;

  cora_serial u_serial (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ser_start),
    .item   (in_item),
    .latest (latest_r),
    .res    (ser)
  );

  cora_div #(
    .DW (FW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (fill_nxt),
    .done     (div_done),
    .quotient (div_q)
  );

  // rtt saturation: 64-bit difference fits when its upper bits match the sign
  always_comb begin
    rtt_fits = (&ser.rtt_diff[CORA_SER_W-1:RW-1]) | ~(|ser.rtt_diff[CORA_SER_W-1:RW-1]);
    if (rtt_fits) begin
      rtt_sat = ser.rtt_diff[RW-1:0];
    end else begin
      rtt_sat = ser.rtt_diff[CORA_SER_W-1] ? CORA_RTT_MIN : CORA_RTT_MAX;
    end
  end

  // running sum: add the new sample, drop the overwritten one once full
  always_comb begin
    full     = (fill_r == FW'(WINDOW));
    fill_nxt = full ? fill_r : fill_r + 1'b1;
    sum_nxt  = sum_r + {{(SW-RW){rtt_new_r[RW-1]}}, rtt_new_r}
             - (full ? {{(SW-RW){rd_r[RW-1]}}, rd_r} : SW'(0));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SER;
      end
      S_SER: begin
        if (ser.done) state_nxt = ser.older ? S_DONE : S_UPD;
      end
      S_UPD: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall  = 1'b1;
    ser_start = 1'b0;
    commit    = 1'b0;
    ring_upd  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall  = 1'b0;
        ser_start = in_valid;
      end
      S_SER: begin
        commit = ser.done & ~ser.older;
      end
      S_UPD: begin
        ring_upd  = 1'b1;
        div_start = 1'b1;
      end
      S_DIV: begin
      end
      S_DONE: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // held state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latest_r <= '0;
      prior_r  <= '0;
      off_r    <= '0;
      sum_r    <= '0;
      avg_r    <= '0;
      pos_r    <= '0;
      fill_r   <= '0;
      acc_r    <= 1'b0;
    end else begin
      if (state_r == S_SER && ser.done) begin
        acc_r <= ~ser.older;
      end
      if (commit) begin
        prior_r  <= latest_r;
        latest_r <= in_center_r;
        off_r    <= ser.offset;
      end
      if (ring_upd) begin
        sum_r  <= sum_nxt;
        fill_r <= fill_nxt;
        pos_r  <= (pos_r == PW'(WINDOW - 1)) ? '0 : pos_r + 1'b1;
      end
      if (div_done) begin
        avg_r <= div_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_start) begin
      in_center_r <= in_item.center_time;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rtt_new_r <= rtt_sat;
    end
  end

  // ring write and registered read at the current slot
  always_ff @(posedge clk) begin
    if (ring_upd) begin
      ring_mem[pos_r] <= rtt_new_r;
    end
    rd_r <= ring_mem[pos_r];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r.accepted             <= acc_r;
      out_item_r.time_offset          <= off_r;
      out_item_r.average_rtt          <= avg_r;
      out_item_r.previous_center_time <= prior_r;
      out_item_r.samples_held         <= CORA_HELD_W'(fill_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(WINDOW))
    else $error("fill count above window");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(WINDOW - 1))
    else $error("ring position out of range");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide phase");

  a_ser_owner: assert property (@(posedge clk) disable iff (!rst_n)
    ser.done |-> state_r == S_SER)
    else $error("serial pass finished outside its phase");

  a_commit_order: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> latest_r == in_center_r)
    else $error("latest center time not taken from the accepted reply");

endmodule

`default_nettype wire
